// File: design/gamma_delta_run_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// Gamma run encoder assertion macros
// Shared concurrent assertion forms, clocked on aclk and off during reset.
// ----------------------------------------------------------------------------
`ifndef GAMMA_DELTA_RUN_ENCODER_CORE_DEFINES_SVH
`define GAMMA_DELTA_RUN_ENCODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDRE_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gamma run encoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define GDRE_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gamma run encoder check failed");

`endif

// File: design/gdre_pkg.sv
// ----------------------------------------------------------------------------
// Gamma run encoder package
// Result kinds, result and bundle structures shared by the encoder stages.
// ----------------------------------------------------------------------------
`default_nettype none

package gdre_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_W  = 20;
    localparam int USED_W = 5;
    localparam int NSLOT  = 4;
    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_MARKER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [WORD_W-1:0]  word;
        logic [IDX_W-1:0]   word_index;
        logic [USED_W-1:0]  bits_used;
        logic               last_out;
    } result_t;

    // All results caused by one input, packed from slot 0 up.
    typedef struct packed {
        result_t [NSLOT-1:0] slot;
        logic [1:0]          last_slot;
    } bundle_t;

    typedef struct packed {
        logic [WORD_W-1:0] code;
        logic [4:0]        msb;
        logic              start;
        logic              zero;
        logic              last;
    } code_item_t;

endpackage

`default_nettype wire

// File: design/gdre_code_stage.sv
// ----------------------------------------------------------------------------
// Gamma run encoder code stage
// Registers the input, selects raw value or gap and finds the leading one.
// ----------------------------------------------------------------------------
`default_nettype none

module gdre_code_stage import gdre_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              delta_enable,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] in_value,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output code_item_t        out_item
);

    logic              hold_valid_reg;
    logic [WORD_W-1:0] value_reg;
    logic              last_reg;
    logic [WORD_W-1:0] prev_reg;
    logic              have_prev_reg;

    logic              start;
    logic [WORD_W-1:0] code;
    logic [4:0]        msb;
    logic              move;

    assign in_ready  = !hold_valid_reg || out_ready;
    assign out_valid = hold_valid_reg;
    assign move      = hold_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            prev_reg       <= '0;
            have_prev_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                hold_valid_reg <= in_valid;
            end
            // The previous value is only meaningful while a stream is open.
            if (move) begin
                prev_reg      <= value_reg;
                have_prev_reg <= !last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            value_reg <= in_value;
            last_reg  <= in_last;
        end
    end

    always_comb begin
        start = delta_enable && (!have_prev_reg || (value_reg < prev_reg));
        code  = (delta_enable && !start) ? (value_reg - prev_reg) : value_reg;
        msb   = 5'd0;
        for (int i = 1; i < WORD_W; i++) begin
            if (code[i]) begin
                msb = 5'(i);
            end
        end
    end

    assign out_item.code  = code;
    assign out_item.msb   = msb;
    assign out_item.start = start;
    assign out_item.zero  = (code == '0);
    assign out_item.last  = last_reg;

endmodule

`default_nettype wire

// File: design/gdre_pack_stage.sv
// ----------------------------------------------------------------------------
// Gamma run encoder pack stage
// Places each gamma code into the bit accumulator and forms the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module gdre_pack_stage import gdre_pkg::*; #(
    parameter int MAX_WORDS = 1048576
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  code_item_t in_item,
    output logic       push_valid,
    input  logic       push_ready,
    output bundle_t    push_bundle
);

    localparam int CW = $clog2(MAX_WORDS);

    logic              item_valid_reg;
    code_item_t        item_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [4:0]        filled_reg;
    logic [CW-1:0]     cnt_reg;

    logic [WORD_W-1:0] acc_next;
    logic [4:0]        filled_next;
    logic [CW-1:0]     cnt_next;

    logic [5:0]        code_len;
    logic [6:0]        total;
    logic [6:0]        shamt;
    logic [95:0]       window;
    logic [1:0]        nfull;
    logic [CW-1:0]     cnt1;
    logic [CW-1:0]     cnt2;
    result_t [4:0]     cand;
    logic [4:0]        cand_valid;
    result_t [NSLOT-1:0] slot;
    logic [2:0]        pos;
    logic [1:0]        last_slot;
    logic              has_result;
    logic              move;

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
        return (c == CW'(MAX_WORDS - 1)) ? '0 : c + CW'(1);
    endfunction

    function automatic logic [IDX_W-1:0] to_index(input logic [CW-1:0] c);
        logic [CW+IDX_W-1:0] e;
        e = {{IDX_W{1'b0}}, c};
        return e[IDX_W-1:0];
    endfunction

    // An input that only adds bits to the partial word pushes nothing.
    assign has_result = (pos != 3'd0);
    assign in_ready   = !item_valid_reg || push_ready || !has_result;
    assign push_valid = item_valid_reg && has_result;
    assign move       = item_valid_reg && (push_ready || !has_result);

    always_comb begin
        // A code of 2n+1 bits lands right after the filled bits; its leading
        // zeros come for free from the empty window.
        code_len = {item_reg.msb, 1'b1};
        total    = 7'(filled_reg) + 7'(code_len);
        shamt    = 7'd96 - total;
        window   = {acc_reg, 64'd0} | ({64'd0, item_reg.code} << shamt);
        nfull    = total[6:5];
        cnt1     = bump(cnt_reg);
        cnt2     = bump(cnt1);

        if (item_reg.zero) begin
            acc_next    = acc_reg;
            filled_next = filled_reg;
            cnt_next    = cnt_reg;
        end else begin
            filled_next = total[4:0];
            case (nfull)
                2'd0: begin
                    acc_next = window[95:64];
                    cnt_next = cnt_reg;
                end
                2'd1: begin
                    acc_next = window[63:32];
                    cnt_next = cnt1;
                end
                default: begin
                    acc_next = window[31:0];
                    cnt_next = cnt2;
                end
            endcase
        end

        cand[0] = '{KIND_MARKER, '0, to_index(cnt_reg), filled_reg, 1'b0};
        cand[1] = '{KIND_ERROR, '0, to_index(cnt_reg), filled_reg, 1'b0};
        cand[2] = '{KIND_WORD, window[95:64], to_index(cnt_reg), '0, 1'b0};
        cand[3] = '{KIND_WORD, window[63:32], to_index(cnt1), '0, 1'b0};
        cand[4] = '{KIND_WORD, acc_next, to_index(cnt_next), '0, 1'b0};

        cand_valid[0] = item_reg.start;
        cand_valid[1] = item_reg.zero;
        cand_valid[2] = !item_reg.zero && (nfull != 2'd0);
        cand_valid[3] = !item_reg.zero && (nfull == 2'd2);
        cand_valid[4] = item_reg.last && (filled_next != 5'd0);

        slot = '0;
        pos  = 3'd0;
        for (int i = 0; i < 5; i++) begin
            if (cand_valid[i]) begin
                slot[pos[1:0]] = cand[i];
                pos = pos + 3'd1;
            end
        end
        // Only meaningful when the input caused at least one result, which a
        // final input always does.
        last_slot = 2'(pos - 3'd1);
        slot[last_slot].last_out = item_reg.last;
    end

    assign push_bundle.slot      = slot;
    assign push_bundle.last_slot = last_slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            acc_reg        <= '0;
            filled_reg     <= '0;
            cnt_reg        <= '0;
        end else begin
            if (in_ready) begin
                item_valid_reg <= in_valid;
            end
            if (move) begin
                if (item_reg.last) begin
                    acc_reg    <= '0;
                    filled_reg <= '0;
                    cnt_reg    <= '0;
                end else begin
                    acc_reg    <= acc_next;
                    filled_reg <= filled_next;
                    cnt_reg    <= cnt_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: design/gdre_result_queue.sv
// ----------------------------------------------------------------------------
// Gamma run encoder result queue
// Buffers result bundles and sends their results one transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module gdre_result_queue import gdre_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_valid,
    output logic    push_ready,
    input  bundle_t push_bundle,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    localparam int PW = $clog2(QDEPTH);
    localparam int NW = $clog2(QDEPTH + 1);

    bundle_t         mem_reg [QDEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [NW-1:0]   count_reg;
    logic [1:0]      sub_reg;
    logic            out_valid_reg;
    result_t         out_reg;

    bundle_t         head;
    logic            push;
    logic            load;
    logic            pop;

    assign push_ready = (count_reg != NW'(QDEPTH));
    assign push       = push_valid && push_ready;
    assign head       = mem_reg[rptr_reg];
    assign load       = (count_reg != '0) && (!out_valid_reg || m_ready);
    assign pop        = load && (sub_reg == head.last_slot);

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_bundle;
        end
        if (load) begin
            out_reg <= head.slot[sub_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            count_reg     <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + PW'(1);
                sub_reg  <= '0;
            end else if (load) begin
                sub_reg <= sub_reg + 2'd1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - NW'(1);
            end
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= load;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/gamma_delta_run_encoder_core.sv
// An input's first result passes the code, pack, queue memory and output registers.
// Throughput: one input per cycle unless the result queue is full; the output sends one result
// per cycle while m_tready is high, so a four-bundle result queue absorbs multi-result inputs.
// The code and pack stages are each registered; the pack stage holds the bit accumulator.
// Reset clears the stream state and the queue and sets delta_enable to 1.
// ----------------------------------------------------------------------------
// Gamma run encoder core
// Elias gamma coding of values or run gaps, packed into indexed 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gamma_delta_run_encoder_core_defines.svh"

module gamma_delta_run_encoder_core import gdre_pkg::*; #(
    parameter int MAX_WORDS = 1048576
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // delta_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // value[31:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // word[31:0], word_index[51:32], bits_used[56:52]
    output logic [1:0]  m_tuser,       // kind[1:0]
    output logic        m_tlast
);

    logic       delta_enable_reg;
    logic       code_valid;
    logic       code_ready;
    code_item_t code_item;
    logic       q_valid;
    logic       q_ready;
    bundle_t    q_bundle;
    result_t    m_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_enable_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            delta_enable_reg <= cfg_data;
        end
    end

    gdre_code_stage u_code (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .delta_enable (delta_enable_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_value     (s_tdata),
        .in_last      (s_tlast),
        .out_valid    (code_valid),
        .out_ready    (code_ready),
        .out_item     (code_item)
    );

    gdre_pack_stage #(
        .MAX_WORDS (MAX_WORDS)
    ) u_pack (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (code_valid),
        .in_ready    (code_ready),
        .in_item     (code_item),
        .push_valid  (q_valid),
        .push_ready  (q_ready),
        .push_bundle (q_bundle)
    );

    gdre_result_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_valid  (q_valid),
        .push_ready  (q_ready),
        .push_bundle (q_bundle),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (m_result)
    );

    assign m_tdata = {7'd0, m_result.bits_used, m_result.word_index, m_result.word};
    assign m_tuser = m_result.kind;
    assign m_tlast = m_result.last_out;

    // A marker carries only a position, never code bits.
    `GDRE_CHECK_NOW(a_marker_no_bits, m_tvalid && (m_tuser == KIND_MARKER), m_tdata[31:0] == 32'd0)
    // Packed words never report a bit position.
    `GDRE_CHECK_NOW(a_word_no_used, m_tvalid && (m_tuser == KIND_WORD), m_tdata[56:52] == 5'd0)
    // The input side stalls only when the result queue is full.
    `GDRE_CHECK_NOW(a_stall_needs_full, !s_tready, !q_ready)
    // The mode register changes only through a configuration transaction.
    `GDRE_CHECK_NEXT(a_cfg_stable, !(cfg_valid && cfg_ready), $stable(delta_enable_reg))

endmodule

`default_nettype wire
